// ===== rtl/bfcm_pkg.sv =====
package bfcm_pkg;

  localparam int unsigned FILE_W = 8;
  localparam int unsigned PAGE_W = 20;
  localparam int unsigned PINS_W = 8;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned IDX_OUT_W = 4;

  // request codes
  typedef enum logic [CMD_W-1:0] {
    CMD_READ    = 3'd0,
    CMD_UNPIN   = 3'd1,
    CMD_ALLOC   = 3'd2,
    CMD_DISPOSE = 3'd3,
    CMD_FLUSH   = 3'd4
  } cmd_e;

  // result beat kinds
  typedef enum logic [1:0] {
    KIND_WB    = 2'd0,
    KIND_FETCH = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  // completion status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BUF_EXCEED  = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_NOT_PINNED  = 3'd3,
    ST_PAGE_PINNED = 3'd4
  } status_e;

  // frame table operations
  typedef enum logic [3:0] {
    FOP_NONE,
    FOP_HIT_READ,
    FOP_UNPIN,
    FOP_CLEAR_HIT,
    FOP_SWEEP_SKIP,
    FOP_CLEAR_PTR,
    FOP_SET_HAND,
    FOP_FLUSH_INV,
    FOP_FLUSH_SKIP
  } fop_e;

  // frame index source of a result beat
  typedef enum logic [1:0] {
    IDX_ZERO,
    IDX_HIT,
    IDX_PTR
  } idx_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     latch;
    logic     match;
    logic     rd_walk;
    fop_e     fop;
    logic     emit;
    kind_e    kind;
    status_e  status;
    idx_sel_e idx_sel;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_e req_cmd;
    logic hit;
    logic hit_pins_zero;
    logic ent_valid;
    logic ent_pinned;
    logic ent_ref;
    logic ent_dirty;
    logic ent_file_eq;
    logic sweep_end;
    logic walk_end;
    logic out_free;
  } dp_st_t;

endpackage

// ===== rtl/buffer_frame_clock_manager.sv =====
// Buffer pool frame manager with clock replacement.
// Input channel: one request beat (cmd, file, page, dirty flag) per
// in_valid_i/in_stall_o handshake; in_stall_o is high while a request is
// being worked on, so one request is handled at a time.
// Output channel: one or more result beats per request (writeback, fetch,
// then a completion with last_o set) over out_valid_o/out_stall_i.
// A read miss or an allocate walks the clock sweep (at most 2*NUM_FRAMES
// steps) and a flush walks the frame table; both walks take one frame a
// cycle while no writeback waits on a stalled output register. A lookup
// hit, unpin or dispose needs no walk.
// Results go through a single output register: a stall from the receiver
// holds the beat and halts the controller when the next beat is due, and
// the next request is taken while the final completion still waits.
// Reset empties the frame table at once (all frames invalid, no pins) and
// parks the clock hand on the last frame.
module buffer_frame_clock_manager #(
  parameter int unsigned NUM_FRAMES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bfcm_pkg::CMD_W-1:0]    cmd_i,
  input  logic [bfcm_pkg::FILE_W-1:0]   file_id_i,
  input  logic [bfcm_pkg::PAGE_W-1:0]   page_no_i,
  input  logic                          dirty_flag_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [2:0]                    status_o,
  output logic [bfcm_pkg::IDX_OUT_W-1:0] frame_index_o,
  output logic [bfcm_pkg::FILE_W-1:0]   out_file_id_o,
  output logic [bfcm_pkg::PAGE_W-1:0]   out_page_no_o,
  output logic                          last_o
);
  import bfcm_pkg::*;

  ctl_cmd_t ctl;
  dp_st_t   st;

  // sequencer
  bfcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (ctl)
  );

  // frame table and output register
  bfcm_dp #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_i),
    .file_id_i     (file_id_i),
    .page_no_i     (page_no_i),
    .dirty_flag_i  (dirty_flag_i),
    .ctl_i         (ctl),
    .st_o          (st),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .status_o      (status_o),
    .frame_index_o (frame_index_o),
    .out_file_id_o (out_file_id_o),
    .out_page_no_o (out_page_no_o),
    .last_o        (last_o)
  );

endmodule

// ===== rtl/bfcm_ctrl.sv =====
module bfcm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bfcm_pkg::dp_st_t  st_i,
  output bfcm_pkg::ctl_cmd_t cmd_o
);
  import bfcm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MATCH = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_SWEEP = 7'b0001000,
    S_SET   = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.fop      = FOP_NONE;
    cmd_o.kind     = KIND_DONE;
    cmd_o.status   = ST_OK;
    cmd_o.idx_sel  = IDX_ZERO;
    cmd_o.rd_walk  = (state_q == S_FLUSH);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        unique case (st_i.req_cmd)
          CMD_READ: begin
            if (!st_i.hit) begin
              state_d = S_SWEEP;
            end else if (st_i.out_free) begin
              cmd_o.fop     = FOP_HIT_READ;
              cmd_o.emit    = 1'b1;
              cmd_o.idx_sel = IDX_HIT;
              state_d       = S_IDLE;
            end
          end
          CMD_ALLOC: begin
            if (st_i.hit) cmd_o.fop = FOP_CLEAR_HIT;
            state_d = S_SWEEP;
          end
          CMD_UNPIN: begin
            if (st_i.out_free) begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
              if (!st_i.hit) begin
                cmd_o.status = ST_NOT_FOUND;
              end else if (st_i.hit_pins_zero) begin
                cmd_o.status  = ST_NOT_PINNED;
                cmd_o.idx_sel = IDX_HIT;
              end else begin
                cmd_o.fop     = FOP_UNPIN;
                cmd_o.idx_sel = IDX_HIT;
              end
            end
          end
          CMD_DISPOSE: begin
            if (st_i.out_free) begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
              if (st_i.hit) begin
                cmd_o.fop     = FOP_CLEAR_HIT;
                cmd_o.idx_sel = IDX_HIT;
              end
            end
          end
          CMD_FLUSH: state_d = S_FLUSH;
          default: begin
            if (st_i.out_free) begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
            end
          end
        endcase
      end
      S_SWEEP: begin
        priority if (st_i.sweep_end) begin
          if (st_i.out_free) begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = ST_BUF_EXCEED;
            state_d      = S_IDLE;
          end
        end else if (!st_i.ent_valid) begin
          state_d = S_SET;
        end else if (!st_i.ent_pinned && !st_i.ent_ref) begin
          if (!st_i.ent_dirty) begin
            cmd_o.fop = FOP_CLEAR_PTR;
            state_d   = S_SET;
          end else if (st_i.out_free) begin
            cmd_o.fop     = FOP_CLEAR_PTR;
            cmd_o.emit    = 1'b1;
            cmd_o.kind    = KIND_WB;
            cmd_o.idx_sel = IDX_PTR;
            state_d       = S_SET;
          end
        end else begin
          cmd_o.fop = FOP_SWEEP_SKIP;
        end
      end
      S_SET: begin
        if (st_i.req_cmd != CMD_READ) begin
          cmd_o.fop = FOP_SET_HAND;
          state_d   = S_DONE;
        end else if (st_i.out_free) begin
          cmd_o.fop     = FOP_SET_HAND;
          cmd_o.emit    = 1'b1;
          cmd_o.kind    = KIND_FETCH;
          cmd_o.idx_sel = IDX_PTR;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.idx_sel = IDX_PTR;
          state_d       = S_IDLE;
        end
      end
      S_FLUSH: begin
        priority if (st_i.walk_end) begin
          if (st_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = S_IDLE;
          end
        end else if (st_i.ent_valid && st_i.ent_file_eq) begin
          if (st_i.ent_pinned) begin
            if (st_i.out_free) begin
              cmd_o.emit    = 1'b1;
              cmd_o.status  = ST_PAGE_PINNED;
              cmd_o.idx_sel = IDX_PTR;
              state_d       = S_IDLE;
            end
          end else if (!st_i.ent_dirty) begin
            cmd_o.fop = FOP_FLUSH_INV;
          end else if (st_i.out_free) begin
            cmd_o.fop     = FOP_FLUSH_INV;
            cmd_o.emit    = 1'b1;
            cmd_o.kind    = KIND_WB;
            cmd_o.idx_sel = IDX_PTR;
          end
        end else begin
          cmd_o.fop = FOP_FLUSH_SKIP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/bfcm_dp.sv =====
module bfcm_dp #(
  parameter int unsigned NUM_FRAMES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bfcm_pkg::CMD_W-1:0]    cmd_i,
  input  logic [bfcm_pkg::FILE_W-1:0]   file_id_i,
  input  logic [bfcm_pkg::PAGE_W-1:0]   page_no_i,
  input  logic                          dirty_flag_i,
  input  bfcm_pkg::ctl_cmd_t            ctl_i,
  output bfcm_pkg::dp_st_t              st_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [2:0]                    status_o,
  output logic [bfcm_pkg::IDX_OUT_W-1:0] frame_index_o,
  output logic [bfcm_pkg::FILE_W-1:0]   out_file_id_o,
  output logic [bfcm_pkg::PAGE_W-1:0]   out_page_no_o,
  output logic                          last_o
);
  import bfcm_pkg::*;

  localparam int unsigned FW = $clog2(NUM_FRAMES);
  localparam int unsigned SW = $clog2(2 * NUM_FRAMES + 1);
  localparam int unsigned WW = $clog2(NUM_FRAMES + 1);

  // request registers
  logic [CMD_W-1:0]  req_cmd_q;
  logic [FILE_W-1:0] req_file_q;
  logic [PAGE_W-1:0] req_page_q;
  logic              req_dflag_q;

  // frame table
  logic [NUM_FRAMES-1:0] valid_q, dirty_q, ref_q;
  logic [PINS_W-1:0]     pins_q [NUM_FRAMES];
  logic [FILE_W-1:0]     file_q [NUM_FRAMES];
  logic [PAGE_W-1:0]     page_q [NUM_FRAMES];

  logic [FW-1:0] hand_q;
  logic [SW-1:0] step_q;
  logic [WW-1:0] walk_q;

  logic                  hit_q, hit_pz_q;
  logic [FW-1:0]         hit_idx_q;
  logic [NUM_FRAMES-1:0] sel_q;

  logic                  out_valid_q;
  kind_e                 out_kind_q;
  status_e               out_status_q;
  logic [IDX_OUT_W-1:0]  out_idx_q;
  logic [FILE_W-1:0]     out_file_q;
  logic [PAGE_W-1:0]     out_page_q;

  logic [FW-1:0]         ptr;
  logic                  out_free;
  logic [NUM_FRAMES-1:0] match, sel_d, pz_lane;
  logic                  hit_d;
  logic [FW-1:0]         hit_idx_d;
  logic [FW-1:0]         idx_pick;
  logic [FW+IDX_OUT_W-1:0] idx_wide;

  assign ptr      = ctl_i.rd_walk ? walk_q[FW-1:0] : hand_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // associative lookup over all frames
  always_comb begin
    hit_d     = 1'b0;
    hit_idx_d = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      match[i]   = valid_q[i] && (file_q[i] == req_file_q) && (page_q[i] == req_page_q);
      pz_lane[i] = (pins_q[i] == '0);
      if (match[i]) begin
        hit_d     = 1'b1;
        hit_idx_d = FW'(i);
      end
    end
    for (int i = 0; i < NUM_FRAMES; i++) begin
      sel_d[i] = hit_d && (hit_idx_d == FW'(i));
    end
  end

  // status to the controller
  always_comb begin
    st_o.req_cmd       = cmd_e'(req_cmd_q);
    st_o.hit           = hit_q;
    st_o.hit_pins_zero = hit_pz_q;
    st_o.ent_valid     = valid_q[ptr];
    st_o.ent_pinned    = (pins_q[ptr] != '0);
    st_o.ent_ref       = ref_q[ptr];
    st_o.ent_dirty     = dirty_q[ptr];
    st_o.ent_file_eq   = (file_q[ptr] == req_file_q);
    st_o.sweep_end     = (step_q == SW'(2 * NUM_FRAMES));
    st_o.walk_end      = (walk_q == WW'(NUM_FRAMES));
    st_o.out_free      = out_free;
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      req_cmd_q   <= cmd_i;
      req_file_q  <= file_id_i;
      req_page_q  <= page_no_i;
      req_dflag_q <= dirty_flag_i;
    end
  end

  // lookup result, hand and walk counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= 1'b0;
      hit_pz_q  <= 1'b0;
      hit_idx_q <= '0;
      sel_q     <= '0;
      hand_q    <= FW'(NUM_FRAMES - 1);
      step_q    <= '0;
      walk_q    <= '0;
    end else begin
      if (ctl_i.match) begin
        hit_q     <= hit_d;
        hit_pz_q  <= |(sel_d & pz_lane);
        hit_idx_q <= hit_idx_d;
        sel_q     <= sel_d;
      end
      if (ctl_i.latch) begin
        step_q <= '0;
        walk_q <= '0;
      end
      if (ctl_i.fop == FOP_SWEEP_SKIP) begin
        hand_q <= (hand_q == FW'(NUM_FRAMES - 1)) ? '0 : hand_q + 1'b1;
        step_q <= step_q + 1'b1;
      end
      if (ctl_i.fop == FOP_FLUSH_INV || ctl_i.fop == FOP_FLUSH_SKIP) begin
        walk_q <= walk_q + 1'b1;
      end
    end
  end

  // frame control bits, one lane per frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      ref_q   <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) pins_q[i] <= '0;
    end else begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        unique case (ctl_i.fop)
          FOP_HIT_READ: begin
            if (sel_q[i]) begin
              if (pins_q[i] != '1) pins_q[i] <= pins_q[i] + 1'b1;
              ref_q[i] <= 1'b1;
            end
          end
          FOP_UNPIN: begin
            if (sel_q[i]) begin
              dirty_q[i] <= dirty_q[i] | req_dflag_q;
              pins_q[i]  <= pins_q[i] - 1'b1;
            end
          end
          FOP_CLEAR_HIT: begin
            if (sel_q[i]) begin
              valid_q[i] <= 1'b0;
              dirty_q[i] <= 1'b0;
              ref_q[i]   <= 1'b0;
              pins_q[i]  <= '0;
            end
          end
          FOP_SWEEP_SKIP: begin
            if (ptr == FW'(i) && pins_q[i] == '0) ref_q[i] <= 1'b0;
          end
          FOP_CLEAR_PTR: begin
            if (ptr == FW'(i)) begin
              valid_q[i] <= 1'b0;
              dirty_q[i] <= 1'b0;
              ref_q[i]   <= 1'b0;
              pins_q[i]  <= '0;
            end
          end
          FOP_SET_HAND: begin
            if (ptr == FW'(i)) begin
              valid_q[i] <= 1'b1;
              dirty_q[i] <= 1'b0;
              ref_q[i]   <= 1'b1;
              pins_q[i]  <= PINS_W'(1);
            end
          end
          FOP_FLUSH_INV: begin
            if (ptr == FW'(i)) begin
              valid_q[i] <= 1'b0;
              dirty_q[i] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // frame tags
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (ctl_i.fop == FOP_SET_HAND && ptr == FW'(i)) begin
        file_q[i] <= req_file_q;
        page_q[i] <= req_page_q;
      end
    end
  end

  // frame number of the result beat, cut to the field width
  always_comb begin
    unique case (ctl_i.idx_sel)
      IDX_HIT: idx_pick = hit_idx_q;
      IDX_PTR: idx_pick = ptr;
      default: idx_pick = '0;
    endcase
    idx_wide = {{IDX_OUT_W{1'b0}}, idx_pick};
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= ctl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      out_kind_q   <= ctl_i.kind;
      out_status_q <= ctl_i.status;
      out_idx_q    <= idx_wide[IDX_OUT_W-1:0];
      if (ctl_i.kind == KIND_WB) begin
        out_file_q <= file_q[ptr];
        out_page_q <= page_q[ptr];
      end else begin
        out_file_q <= req_file_q;
        out_page_q <= req_page_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign status_o      = out_status_q;
  assign frame_index_o = out_idx_q;
  assign out_file_id_o = out_file_q;
  assign out_page_no_o = out_page_q;
  assign last_o        = (out_kind_q == KIND_DONE);

`ifndef SYNTHESIS
  a_hand_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hand_q < FW'(NUM_FRAMES - 1) || hand_q == FW'(NUM_FRAMES - 1))
    else $error("clock hand beyond last frame");
  a_hit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> $onehot(sel_q))
    else $error("lookup hit without a single selected frame");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.emit |-> out_free)
    else $error("result beat issued into a full output register");
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_q <= WW'(NUM_FRAMES))
    else $error("flush walk beyond frame count");
`endif

endmodule

// ===== sim/bfcm_checker.sv =====
`timescale 1ns / 1ps

module bfcm_checker #(
  parameter int unsigned NUM_FRAMES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  file_id_i,
  input  logic [19:0] page_no_i,
  input  logic        dirty_flag_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  status_i,
  input  logic [3:0]  frame_index_i,
  input  logic [7:0]  out_file_id_i,
  input  logic [19:0] out_page_no_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  import bfcm_pkg::*;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [3:0]  frame;
    logic [7:0]  file;
    logic [19:0] page;
    logic        last;
  } beat_t;

  beat_t       expected_beats[$];
  logic        fr_valid[NUM_FRAMES];
  logic        fr_dirty[NUM_FRAMES];
  logic        fr_ref[NUM_FRAMES];
  logic [7:0]  fr_pins[NUM_FRAMES];
  logic [7:0]  fr_file[NUM_FRAMES];
  logic [19:0] fr_page[NUM_FRAMES];
  int unsigned hand;

  assign pending_o = expected_beats.size();

  function automatic void push_beat(kind_e k, status_e s, int unsigned f,
                                    logic [7:0] fl, logic [19:0] pg, logic l);
    beat_t b;
    b.kind = k; b.status = s; b.frame = f[3:0]; b.file = fl; b.page = pg; b.last = l;
    expected_beats.push_back(b);
  endfunction

  function automatic void wipe_frame(int unsigned f);
    fr_valid[f] = 0; fr_dirty[f] = 0; fr_ref[f] = 0;
    fr_pins[f] = 0; fr_file[f] = 0; fr_page[f] = 0;
  endfunction

  function automatic int find_page(logic [7:0] fl, logic [19:0] pg);
    for (int i = 0; i < NUM_FRAMES; i++)
      if (fr_valid[i] && fr_file[i] == fl && fr_page[i] == pg) return i;
    return -1;
  endfunction

  // clock sweep for a victim frame
  function automatic int pick_victim();
    int unsigned h;
    for (int s = 0; s < 2 * NUM_FRAMES; s++) begin
      h = hand % NUM_FRAMES;
      hand = h;
      if (!fr_valid[h]) return h;
      if (fr_pins[h] == 0 && !fr_ref[h]) begin
        if (fr_dirty[h]) push_beat(KIND_WB, ST_OK, h, fr_file[h], fr_page[h], 1'b0);
        wipe_frame(h);
        return h;
      end
      if (fr_pins[h] == 0) fr_ref[h] = 0;
      hand = (h + 1) % NUM_FRAMES;
    end
    return -1;
  endfunction

  function automatic void predict_request(logic [2:0] c, logic [7:0] fl,
                                          logic [19:0] pg, logic df);
    int f;
    case (c)
      CMD_READ, CMD_ALLOC: begin
        f = find_page(fl, pg);
        if (c == CMD_READ && f >= 0) begin
          if (fr_pins[f] < 8'd255) fr_pins[f]++;
          fr_ref[f] = 1;
          push_beat(KIND_DONE, ST_OK, f, fl, pg, 1'b1);
        end else begin
          if (c == CMD_ALLOC && f >= 0) wipe_frame(f);
          f = pick_victim();
          if (f < 0) push_beat(KIND_DONE, ST_BUF_EXCEED, 0, fl, pg, 1'b1);
          else begin
            fr_valid[f] = 1; fr_dirty[f] = 0; fr_ref[f] = 1; fr_pins[f] = 1;
            fr_file[f] = fl; fr_page[f] = pg;
            if (c == CMD_READ) push_beat(KIND_FETCH, ST_OK, f, fl, pg, 1'b0);
            push_beat(KIND_DONE, ST_OK, f, fl, pg, 1'b1);
          end
        end
      end
      CMD_UNPIN: begin
        f = find_page(fl, pg);
        if (f < 0) push_beat(KIND_DONE, ST_NOT_FOUND, 0, fl, pg, 1'b1);
        else if (fr_pins[f] == 0) push_beat(KIND_DONE, ST_NOT_PINNED, f, fl, pg, 1'b1);
        else begin
          if (df) fr_dirty[f] = 1;
          fr_pins[f]--;
          push_beat(KIND_DONE, ST_OK, f, fl, pg, 1'b1);
        end
      end
      CMD_DISPOSE: begin
        f = find_page(fl, pg);
        if (f >= 0) wipe_frame(f);
        push_beat(KIND_DONE, ST_OK, (f >= 0) ? f : 0, fl, pg, 1'b1);
      end
      CMD_FLUSH: begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
          if (!fr_valid[i] || fr_file[i] != fl) continue;
          if (fr_pins[i] > 0) begin
            push_beat(KIND_DONE, ST_PAGE_PINNED, i, fl, pg, 1'b1);
            return;
          end
          if (fr_dirty[i]) push_beat(KIND_WB, ST_OK, i, fr_file[i], fr_page[i], 1'b0);
          fr_dirty[i] = 0;
          fr_valid[i] = 0;
        end
        push_beat(KIND_DONE, ST_OK, 0, fl, pg, 1'b1);
      end
      default: push_beat(KIND_DONE, ST_OK, 0, fl, pg, 1'b1);
    endcase
  endfunction

  // predict on accepted requests, compare accepted result beats
  always @(posedge clk_i or negedge rst_ni) begin
    beat_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_FRAMES; i++) wipe_frame(i);
      hand = NUM_FRAMES - 1;
      expected_beats.delete();
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat kind=%0d status=%0d frame=%0d", $time,
                   kind_i, status_i, frame_index_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_beats.pop_front();
          if ({kind_i, status_i, frame_index_i, out_file_id_i, out_page_no_i, last_i}
              !== want) begin
            $display("%0t: mismatch expected k=%0d s=%0d f=%0d file=%0h page=%0h l=%0d",
                     $time, want.kind, want.status, want.frame, want.file, want.page,
                     want.last);
            $display("%0t:          actual   k=%0d s=%0d f=%0d file=%0h page=%0h l=%0d",
                     $time, kind_i, status_i, frame_index_i, out_file_id_i,
                     out_page_no_i, last_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_request(cmd_i, file_id_i, page_no_i, dirty_flag_i);
    end
  end

endmodule

// ===== sim/buffer_frame_clock_manager_tb.sv =====
`timescale 1ns / 1ps

module buffer_frame_clock_manager_tb;
  import bfcm_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = '0;
  logic [7:0]  file_id_i = '0;
  logic [19:0] page_no_i = '0;
  logic        dirty_flag_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [2:0]  status_o;
  logic [3:0]  frame_index_o;
  logic [7:0]  out_file_id_o;
  logic [19:0] out_page_no_o;
  logic        last_o;
  int          fail_count;
  int          pending;
  logic        hold_off = 1'b0;
  logic        stall_noise = 1'b0;
  int          burst_left = 0;

  buffer_frame_clock_manager dut (.*);

  bfcm_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .cmd_i, .file_id_i,
    .page_no_i, .dirty_flag_i, .out_valid_i(out_valid_o), .out_stall_i, .kind_i(kind_o),
    .status_i(status_o), .frame_index_i(frame_index_o), .out_file_id_i(out_file_id_o),
    .out_page_no_i(out_page_no_o), .last_i(last_o), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stall pattern: quiet stretches, noisy stretches
  always @(negedge clk_i) begin
    if (($urandom % 64) == 0) stall_noise <= ~stall_noise;
    out_stall_i <= hold_off || (stall_noise && ($urandom % 3 == 0));
  end

  // offer one request beat, wait until accepted; valid drops only for a gap
  task automatic send_beat(logic [2:0] c, logic [7:0] fl, logic [19:0] pg, logic df);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i <= c; file_id_i <= fl; page_no_i <= pg; dirty_flag_i <= df;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // small working set so hits, pins and evictions are common
  task automatic random_beat(bit wide);
    logic [2:0]  c;
    logic [7:0]  fl;
    logic [19:0] pg;
    int r;
    r = $urandom_range(0, 99);
    c = r < 35 ? CMD_READ : r < 65 ? CMD_UNPIN : r < 78 ? CMD_ALLOC :
        r < 88 ? CMD_DISPOSE : r < 96 ? CMD_FLUSH : 3'($urandom_range(5, 7));
    if (wide) begin
      fl = 8'($urandom); pg = 20'($urandom);
    end else begin
      fl = 8'($urandom_range(0, 3)); pg = 20'($urandom_range(0, 11));
    end
    send_beat(c, fl, pg, 1'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: field extremes, every command, special cases
    send_beat(CMD_UNPIN, 8'h00, 20'h0, 1'b0);           // unpin miss
    send_beat(CMD_READ, 8'hff, 20'hfffff, 1'b0);         // miss with fetch
    send_beat(CMD_READ, 8'hff, 20'hfffff, 1'b0);         // hit
    send_beat(CMD_UNPIN, 8'hff, 20'hfffff, 1'b1);
    send_beat(CMD_UNPIN, 8'hff, 20'hfffff, 1'b1);
    send_beat(CMD_UNPIN, 8'hff, 20'hfffff, 1'b0);        // not pinned
    send_beat(CMD_ALLOC, 8'hff, 20'hfffff, 1'b0);        // resident alloc
    send_beat(CMD_FLUSH, 8'hff, 20'h0, 1'b0);            // pinned in flush
    send_beat(CMD_UNPIN, 8'hff, 20'hfffff, 1'b1);
    send_beat(CMD_FLUSH, 8'hff, 20'h0, 1'b0);            // dirty writeback
    send_beat(CMD_DISPOSE, 8'h12, 20'h345, 1'b0);        // dispose miss
    send_beat(3'd7, 8'h55, 20'haaaaa, 1'b1);             // unknown command
    // fill every frame pinned, then overflow the sweep
    for (int i = 0; i < 16; i++) send_beat(CMD_READ, 8'h01, 20'(i), 1'b0);
    send_beat(CMD_ALLOC, 8'h01, 20'h99, 1'b0);           // buffer exceeded
    send_beat(CMD_DISPOSE, 8'h01, 20'h3, 1'b0);          // dispose pinned
    for (int i = 0; i < 16; i++) send_beat(CMD_UNPIN, 8'h01, 20'(i), 1'b1);
    drain_results();
    // receiver holds off while requests keep coming
    hold_off <= 1'b1;
    fork
      begin
        repeat (200) @(negedge clk_i);
        hold_off <= 1'b0;
      end
      for (int i = 0; i < 12; i++) random_beat(1'b0);
    join
    drain_results();
    for (int n = 0; n < 300; n++) begin
      random_beat(($urandom % 10) == 0);
      if (n == 150) drain_results();
    end
    drain_results();
    repeat (60) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule
